// ===== sv/fia_pkg.sv =====
// Shared constants and types for the free index allocator.
package fia_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 256;
   localparam int INDEX_LIMIT         = 256;
   localparam int IDX_W               = 8;
   localparam int CAP_W               = 9;
   localparam int STATUS_W            = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam logic       FUNC_GET        = 1'b0;
   localparam logic       FUNC_PUT        = 1'b1;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_EMPTY    = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

endpackage

// ===== sv/free_index_allocator.sv =====
// Free index allocator: LIFO return stack over a counter of never-issued indices.
//
// Usage:
//   req channel (req_valid/req_ready): req_func selects get (FUNC_GET) or put
//   (FUNC_PUT); req_index_in is the index returned by a put.
//   rsp channel (rsp_valid/rsp_ready): one transfer per request, in order,
//   carrying rsp_index_out and rsp_status (ok, empty get, ignored put).
//   csr port: a write of csr_wr_data on csr_wr_en sets the capacity
//   (0 is taken as 1, values above the pool size saturate) and restarts
//   the pool. Write only while no request is in flight.
// Timing:
//   rsp_valid is registered: a request passes the read stage and then the output
//   register before it is answered. One request per cycle is taken in steady state
//   while rsp_ready stays high; the pool state is updated at the request transfer and
//   the popped entry is read through the registered port of the return-stack memory.
// Reset: no returned indices, all indices fresh, full capacity; stack memory not cleared.
// Stall:
//   With rsp_ready low, the output register holds its result and one more
//   request is taken into the read stage; then req_ready drops.
module free_index_allocator #(
   parameter int MAX_ENTRIES = fia_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [fia_pkg::IDX_W-1:0] req_index_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [fia_pkg::IDX_W-1:0] rsp_index_out,
   output fia_pkg::status_type       rsp_status,
   input  logic                      csr_wr_en,
   input  logic [fia_pkg::CAP_W-1:0] csr_wr_data
);
   import fia_pkg::*;

   localparam int LIMIT  = (MAX_ENTRIES > INDEX_LIMIT) ? INDEX_LIMIT : MAX_ENTRIES;
   localparam int CNT_W  = $clog2(LIMIT + 1);
   localparam int ADDR_W = $clog2(LIMIT);

   logic [IDX_W-1:0]  stack_mem [LIMIT];

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_pop_ff;
   logic [IDX_W-1:0]  s1_index_ff;
   status_type        s1_status_ff;
   logic [IDX_W-1:0]  rd_ff;

   logic              s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]  s2_index_ff;
   status_type        s2_status_ff;

   logic              req_xfer;
   logic              s1_adv;
   logic              do_pop;
   logic              do_push;
   logic              is_empty;
   logic              is_overflow;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  depth_dec;
   logic [IDX_W-1:0]  s1_index_in;
   status_type        s1_status_in;

   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   assign depth_dec = depth_ff - CNT_W'(1);
   assign rd_addr   = depth_dec[ADDR_W-1:0];
   assign wr_addr   = depth_ff[ADDR_W-1:0];

   always_comb begin
      do_pop       = 1'b0;
      do_push      = 1'b0;
      is_empty     = 1'b0;
      is_overflow  = 1'b0;
      s1_index_in  = '0;
      s1_status_in = STATUS_OK;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      if (req_func == FUNC_GET) begin
         if (depth_ff != '0) begin
            do_pop   = 1'b1;
            depth_in = depth_dec;
         end else if (fresh_ff < cap_ff) begin
            s1_index_in = IDX_W'(fresh_ff);
            fresh_in    = fresh_ff + CNT_W'(1);
         end else begin
            is_empty     = 1'b1;
            s1_status_in = STATUS_EMPTY;
         end
      end else begin
         if (fresh_ff == depth_ff) begin
            is_overflow  = 1'b1;
            s1_status_in = STATUS_OVERFLOW;
         end else begin
            do_push  = 1'b1;
            depth_in = depth_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_wr_data > CAP_W'(LIMIT)) begin
         cap_in = CNT_W'(LIMIT);
      end else begin
         cap_in = CNT_W'(csr_wr_data);
      end
   end

   assign s1_valid_in = req_xfer || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CNT_W'(LIMIT);
         depth_ff    <= '0;
         fresh_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (csr_wr_en) begin
            cap_ff   <= cap_in;
            depth_ff <= '0;
            fresh_ff <= '0;
         end else if (req_xfer) begin
            depth_ff <= depth_in;
            fresh_ff <= fresh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && do_push) begin
         stack_mem[wr_addr] <= req_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && do_pop) begin
         rd_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pop_ff    <= do_pop;
         s1_index_ff  <= s1_index_in;
         s1_status_ff <= s1_status_in;
      end
      if (s1_adv) begin
         s2_index_ff  <= s1_pop_ff ? rd_ff : s1_index_ff;
         s2_status_ff <= s1_status_ff;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_index_out = s2_index_ff;
   assign rsp_status    = s2_status_ff;

`ifndef SYNTHESIS
   a_depth_le_fresh: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= fresh_ff)
      else $error("return stack deeper than issued count");

   a_fresh_le_cap: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= cap_ff)
      else $error("fresh counter beyond capacity");

   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      cap_ff != '0 && cap_ff <= CNT_W'(LIMIT))
      else $error("capacity out of range");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !csr_wr_en && (is_overflow || is_empty)
      |=> $stable(depth_ff) && $stable(fresh_ff))
      else $error("rejected request changed pool state");
`endif

endmodule

// ===== tb/free_index_allocator_tb.sv =====
// Self-checking testbench for the free index allocator: pool predictor, random traffic, stalls.
`timescale 1ns / 1ps

module free_index_allocator_tb;
   import fia_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_LEN    = 60;

   typedef struct {
      logic             func;
      logic [IDX_W-1:0] idx;
      bit               drain;
   } pool_req_type;

   typedef struct {
      logic [IDX_W-1:0] index;
      status_type       status;
   } pool_rsp_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic                req_func     = FUNC_GET;
   logic [IDX_W-1:0]    req_index_in = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [IDX_W-1:0]    rsp_index_out;
   status_type          rsp_status;
   logic                csr_wr_en    = 1'b0;
   logic [CAP_W-1:0]    csr_wr_data  = '0;

   pool_req_type        pending_reqs[$];
   pool_rsp_type        expected_rsps[$];
   pool_req_type        cur_req;

   // predictor state
   logic [IDX_W-1:0]    ret_stack [MAX_ENTRIES_DEFAULT];
   int                  ret_depth;
   int                  fresh_cnt;
   int                  pool_cap;

   int                  errors    = 0;
   int                  cycles    = 0;
   int                  drv_gap   = 0;
   int                  drv_burst = 0;
   int                  rcv_gap   = 0;
   int                  rcv_burst = 0;
   int                  hold_cnt  = 0;
   int                  hold_at   = 300;
   int                  rsp_count = 0;

   free_index_allocator u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_index_in  (req_index_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_index_out (rsp_index_out),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int clamp_cap(input logic [CAP_W-1:0] v);
      int lim;
      int c;
      lim = (MAX_ENTRIES_DEFAULT < INDEX_LIMIT) ? MAX_ENTRIES_DEFAULT : INDEX_LIMIT;
      c = int'(v);
      if (c < 1) c = 1;
      if (c > lim) c = lim;
      return c;
   endfunction

   function automatic pool_rsp_type pool_predict(input pool_req_type rq);
      pool_rsp_type e;
      e.index  = '0;
      e.status = STATUS_OK;
      if (rq.func == FUNC_GET) begin
         if (ret_depth > 0) begin
            ret_depth--;
            e.index = ret_stack[ret_depth];
         end else if (fresh_cnt < pool_cap) begin
            e.index = IDX_W'(fresh_cnt);
            fresh_cnt++;
         end else begin
            e.status = STATUS_EMPTY;
         end
      end else begin
         if (fresh_cnt == ret_depth || ret_depth >= MAX_ENTRIES_DEFAULT) begin
            e.status = STATUS_OVERFLOW;
         end else begin
            ret_stack[ret_depth] = rq.idx;
            ret_depth++;
         end
      end
      return e;
   endfunction

   // mostly short gaps, a few long ones, and occasional bursts with none
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic add_req(input logic func, input logic [IDX_W-1:0] idx, input bit drain = 1'b0);
      pool_req_type rq;
      rq.func  = func;
      rq.idx   = idx;
      rq.drain = drain;
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      pool_cap  = clamp_cap(v);
      ret_depth = 0;
      fresh_cnt = 0;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [CAP_W-1:0] cap_raw, input int n_items);
      int               cap;
      int               fill;
      int               seg;
      int               p_get;
      logic [IDX_W-1:0] idx;
      bit               drain;
      write_capacity(cap_raw);
      cap   = clamp_cap(cap_raw);
      fill  = cap + 20;
      seg   = 0;
      p_get = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i < fill) begin
            p_get = 97;
         end else begin
            if (seg == 0) begin
               seg = $urandom_range(4, 40);
               case ($urandom_range(0, 2))
                  0: p_get = 85;
                  1: p_get = 50;
                  default: p_get = 15;
               endcase
            end
            seg--;
         end
         drain = ($urandom_range(0, 199) == 0);
         if ($urandom_range(0, 99) < p_get) begin
            add_req(FUNC_GET, IDX_W'($urandom()), drain);
         end else begin
            if ($urandom_range(0, 1) != 0) idx = IDX_W'($urandom_range(0, cap - 1));
            else idx = IDX_W'($urandom());
            add_req(FUNC_PUT, idx, drain);
         end
      end
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[free_index_allocator] ERROR");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(pool_predict(cur_req));
         end
         if (!req_valid || req_ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && (req_valid || expected_rsps.size() != 0))) begin
               cur_req = pending_reqs.pop_front();
               req_valid    <= 1'b1;
               req_func     <= cur_req.func;
               req_index_in <= cur_req.idx;
               drv_gap = pick_gap(drv_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, counted in cycles
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (rsp_count >= hold_at) begin
         hold_cnt <= HOLD_LEN;
         hold_at  <= hold_at + 400;
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      pool_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer index_out %0d status %0d",
                        $time, rsp_index_out, rsp_status);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_index_out !== e.index || rsp_status !== e.status) begin
                  errors++;
                  $display({"%0t: mismatch expected index_out %0d status %0d, ",
                            "actual index_out %0d status %0d"},
                           $time, e.index, e.status, rsp_index_out, rsp_status);
               end
            end
            rcv_gap = pick_gap(rcv_burst);
         end
         if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
         end else if (rcv_gap > 0) begin
            rcv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      pool_cap  = clamp_cap(CAP_W'(256));
      ret_depth = 0;
      fresh_cnt = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full pool from reset: overflow on an empty issue set, fresh issue, LIFO reuse
      add_req(FUNC_PUT, 8'd5);
      add_req(FUNC_GET, 8'hFF);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_PUT, 8'hFF);
      add_req(FUNC_PUT, 8'h00);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_PUT, 8'hAA, 1'b1);
      add_req(FUNC_GET, 8'h55);

      // capacity 0 taken as 1: empty get, foreign put, overflow
      write_capacity(CAP_W'(0));
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_PUT, 8'h55);
      add_req(FUNC_PUT, 8'h07);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_PUT, 8'hFF);
      add_req(FUNC_GET, 8'h00);

      write_capacity(CAP_W'(256));
      add_req(FUNC_GET, 8'h00);
      add_req(FUNC_PUT, 8'h80);

      // above the pool size saturates
      write_capacity(CAP_W'(511));
      add_req(FUNC_GET, 8'h00);

      run_random_phase(CAP_W'(2), 70);
      run_random_phase(CAP_W'(1), 70);
      run_random_phase(CAP_W'(3), 70);
      run_random_phase(CAP_W'(255), 330);
      run_random_phase(CAP_W'(0), 70);
      run_random_phase(CAP_W'(16), 70);
      run_random_phase(CAP_W'(5), 70);
      run_random_phase(CAP_W'(300), 330);
      run_random_phase(CAP_W'($urandom_range(1, 40)), 70);
      run_random_phase(CAP_W'($urandom_range(1, 40)), 70);

      wait_idle();
      if (errors == 0) begin
         $display("[free_index_allocator] OK");
      end else begin
         $display("[free_index_allocator] ERROR");
      end
      $finish;
   end

endmodule
